[src/jsfe_pkg.sv]
// ----------------------------------------------------------------------------
// jsfe_pkg
// shared types, constants and codes of the json string field extractor
// ----------------------------------------------------------------------------
package jsfe_pkg;

    localparam int KEY_MAX   = 125;
    localparam int VALUE_MAX = 256;
    localparam int WIN       = KEY_MAX + 2;

    localparam int KL_W   = 7;
    localparam int CAP_W  = 9;
    localparam int RAW_W  = 9;
    localparam int BYTE_W = 8;
    localparam int SUM_W  = KL_W + 1;
    localparam int IDX_W  = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    localparam int CFG_AW = 1;
    localparam int CFG_DW = 9;
    localparam logic [CFG_AW-1:0] CFG_KEY_LENGTH     = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_VALUE_CAPACITY = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'((VALUE_MAX < 256) ? VALUE_MAX : 256);

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    localparam logic [BYTE_W-1:0] QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CR     = 8'h0D;

    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_SEARCH = 3'd0;
    localparam logic [PH_W-1:0] PH_COLON  = 3'd1;
    localparam logic [PH_W-1:0] PH_SPACE  = 3'd2;
    localparam logic [PH_W-1:0] PH_VALUE  = 3'd3;
    localparam logic [PH_W-1:0] PH_DONE   = 3'd4;

    localparam int FIFO_DEPTH = 8;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FC_W       = FP_W + 1;
    localparam int MAX_PUSH   = 3;
    localparam int PUSH_W     = 2;

    typedef struct packed {
        logic [BYTE_W-1:0] value_byte;
        logic              is_status;
        logic              found;
    } t_item;

    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] idx;
        logic [BYTE_W-1:0] data;
    } t_key_wr;

    typedef struct packed {
        logic en;
        logic clr;
    } t_shift;

endpackage

[src/jsfe_ram.sv]
// ----------------------------------------------------------------------------
// jsfe_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module jsfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/jsfe_cell.sv]
// ----------------------------------------------------------------------------
// jsfe_cell
// one window position: holds a text byte, its valid bit and the aligned key byte
// ----------------------------------------------------------------------------
module jsfe_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [jsfe_pkg::IDX_W-1:0]    i_idx,
    input  logic [jsfe_pkg::KL_W-1:0]     i_key_len,
    input  jsfe_pkg::t_key_wr             i_key_wr,
    input  jsfe_pkg::t_shift              i_ctl,
    input  logic [jsfe_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_vld,
    output logic [jsfe_pkg::BYTE_W-1:0]   o_byte,
    output logic                          o_vld,
    output logic                          o_ok
);

    logic [jsfe_pkg::BYTE_W-1:0] r_byte;
    logic                        r_vld;
    logic [jsfe_pkg::BYTE_W-1:0] r_key;
    logic [jsfe_pkg::SUM_W-1:0]  pos;
    logic [jsfe_pkg::SUM_W-1:0]  last;
    logic                        hit;
    logic                        care;
    logic [jsfe_pkg::BYTE_W-1:0] want;

    assign pos  = jsfe_pkg::SUM_W'(i_idx);
    assign last = jsfe_pkg::SUM_W'(i_key_len) + jsfe_pkg::SUM_W'(1);
    // key byte k sits at age key_len - k
    assign hit  = (pos + jsfe_pkg::SUM_W'(i_key_wr.idx)) == jsfe_pkg::SUM_W'(i_key_len);
    assign care = pos <= last;

    always_comb begin
        if (pos == '0 || pos == last) begin
            want = jsfe_pkg::QUOTE;
        end else begin
            want = r_key;
        end
    end

    assign o_ok   = !care || (i_vld && (i_byte == want));
    assign o_byte = r_byte;
    assign o_vld  = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.clr) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_byte <= i_byte;
        end
        if (i_key_wr.en && hit) begin
            r_key <= i_key_wr.data;
        end
    end

endmodule

[src/jsfe_fifo.sv]
// ----------------------------------------------------------------------------
// jsfe_fifo
// result queue taking up to three results per cycle and giving one when popped
// ----------------------------------------------------------------------------
module jsfe_fifo (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [jsfe_pkg::PUSH_W-1:0]            i_push_n,
    input  jsfe_pkg::t_item [jsfe_pkg::MAX_PUSH-1:0] i_push,
    input  logic                                   i_pop,
    output logic                                   o_room,
    output logic                                   o_valid,
    output jsfe_pkg::t_item                        o_head
);

    jsfe_pkg::t_item            r_mem [jsfe_pkg::FIFO_DEPTH];
    logic [jsfe_pkg::FP_W-1:0]  r_wr;
    logic [jsfe_pkg::FP_W-1:0]  r_rd;
    logic [jsfe_pkg::FC_W-1:0]  r_cnt;
    logic [jsfe_pkg::FC_W-1:0]  n_cnt;
    logic                       pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];
    assign o_room  = r_cnt <= jsfe_pkg::FC_W'(jsfe_pkg::FIFO_DEPTH - jsfe_pkg::MAX_PUSH);
    assign n_cnt   = r_cnt + jsfe_pkg::FC_W'(i_push_n) - jsfe_pkg::FC_W'(pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < jsfe_pkg::MAX_PUSH; k++) begin
            if (jsfe_pkg::PUSH_W'(k) < i_push_n) begin
                r_mem[r_wr + jsfe_pkg::FP_W'(k)] <= i_push[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + jsfe_pkg::FP_W'(i_push_n);
            r_rd  <= r_rd + jsfe_pkg::FP_W'(pop);
            r_cnt <= n_cnt;
        end
    end

endmodule

[src/json_string_field_extractor.sv]
// ----------------------------------------------------------------------------
// json_string_field_extractor
// finds a quoted key in streamed json text and returns its string value
// ----------------------------------------------------------------------------
// results of a request enter the result queue, behind those already queued
// throughput: one request per cycle while o_stall is low; results leave one per cycle from a queue while i_stall is low
// writing a nonzero key_length stalls requests while the key ram is
// swept into the window cells
// reset is synchronous: control state clears, key store is undefined until loaded
// ----------------------------------------------------------------------------
module json_string_field_extractor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [jsfe_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [jsfe_pkg::KL_W-1:0]     i_key_index,
    input  logic                          i_end_of_text,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [jsfe_pkg::BYTE_W-1:0]   o_value_byte,
    output logic                          o_is_status,
    output logic                          o_found,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [jsfe_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [jsfe_pkg::CFG_DW-1:0]   i_cfg_data
);

    logic [jsfe_pkg::KL_W-1:0]   r_key_len;
    logic [jsfe_pkg::CAP_W-1:0]  r_cap;
    logic [jsfe_pkg::PH_W-1:0]   r_phase;
    logic [jsfe_pkg::PH_W-1:0]   n_phase;
    logic [jsfe_pkg::RAW_W-1:0]  r_raw;
    logic [jsfe_pkg::RAW_W-1:0]  n_raw;
    logic                        r_pend;
    logic                        n_pend;
    logic                        r_sw_busy;
    logic [jsfe_pkg::KEY_AW-1:0] r_sw_cnt;
    logic                        r_rd_vld;
    logic [jsfe_pkg::KEY_AW-1:0] r_rd_idx;

    logic                        in_acc;
    logic                        text_acc;
    logic                        key_load;
    logic                        room;
    logic                        match;
    logic                        is_ws;
    logic                        cont;
    logic [jsfe_pkg::RAW_W-1:0]  limit;
    logic [jsfe_pkg::BYTE_W-1:0] ram_q;
    logic [jsfe_pkg::KL_W-1:0]   cfg_kl;
    logic [jsfe_pkg::CAP_W-1:0]  cfg_cap;
    logic [jsfe_pkg::PUSH_W-1:0] nemit;

    jsfe_pkg::t_item [jsfe_pkg::MAX_PUSH-1:0] items;
    jsfe_pkg::t_item                          head;
    jsfe_pkg::t_key_wr                        key_wr;
    jsfe_pkg::t_shift                         ctl;

    logic [jsfe_pkg::BYTE_W-1:0] w_byte [jsfe_pkg::WIN];
    logic                        w_vld  [jsfe_pkg::WIN];
    logic [jsfe_pkg::WIN-1:0]    ok;

    assign o_stall     = r_sw_busy || r_rd_vld || !room;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !o_stall;
    assign text_acc    = in_acc && (i_command == jsfe_pkg::CMD_TEXT);
    assign key_load    = in_acc && (i_command == jsfe_pkg::CMD_KEY)
                         && (32'(i_key_index) < jsfe_pkg::KEY_MAX);
    assign limit       = (r_cap == '0) ? '0 : jsfe_pkg::RAW_W'(r_cap - jsfe_pkg::CAP_W'(1));
    assign is_ws       = (i_byte_value == jsfe_pkg::SPACE)
                         || (i_byte_value >= jsfe_pkg::TAB && i_byte_value <= jsfe_pkg::CR);
    assign match       = &ok;

    assign cfg_kl  = (32'(i_cfg_data[jsfe_pkg::KL_W-1:0]) > jsfe_pkg::KEY_MAX)
                     ? jsfe_pkg::KL_W'(jsfe_pkg::KEY_MAX) : i_cfg_data[jsfe_pkg::KL_W-1:0];
    assign cfg_cap = (32'(i_cfg_data) > jsfe_pkg::VALUE_MAX)
                     ? jsfe_pkg::CAP_W'(jsfe_pkg::VALUE_MAX) : i_cfg_data;

    // key store and realignment sweep
    jsfe_ram #(
        .WIDTH (jsfe_pkg::BYTE_W),
        .DEPTH (jsfe_pkg::KEY_MAX)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_load),
        .i_waddr (jsfe_pkg::KEY_AW'(i_key_index)),
        .i_wdata (i_byte_value),
        .i_re    (r_sw_busy),
        .i_raddr (r_sw_cnt),
        .o_rdata (ram_q)
    );

    always_comb begin
        if (r_rd_vld) begin
            key_wr.en   = 1'b1;
            key_wr.idx  = r_rd_idx;
            key_wr.data = ram_q;
        end else begin
            key_wr.en   = key_load;
            key_wr.idx  = jsfe_pkg::KEY_AW'(i_key_index);
            key_wr.data = i_byte_value;
        end
    end

    // window cells
    genvar g;
    generate
        for (g = 0; g < jsfe_pkg::WIN; g++) begin : g_cell
            logic [jsfe_pkg::BYTE_W-1:0] c_byte;
            logic                        c_vld;
            if (g == 0) begin : g_head
                assign c_byte = i_byte_value;
                assign c_vld  = 1'b1;
            end else begin : g_body
                assign c_byte = w_byte[g-1];
                assign c_vld  = w_vld[g-1];
            end
            jsfe_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_idx     (jsfe_pkg::IDX_W'(g)),
                .i_key_len (r_key_len),
                .i_key_wr  (key_wr),
                .i_ctl     (ctl),
                .i_byte    (c_byte),
                .i_vld     (c_vld),
                .o_byte    (w_byte[g]),
                .o_vld     (w_vld[g]),
                .o_ok      (ok[g])
            );
        end
    endgenerate

    // phase machine
    always_comb begin
        n_phase = r_phase;
        n_raw   = r_raw;
        n_pend  = r_pend;
        nemit   = '0;
        items   = '0;
        ctl.en  = 1'b0;
        ctl.clr = 1'b0;
        cont    = 1'b1;
        if (text_acc) begin
            unique case (r_phase)
                jsfe_pkg::PH_SEARCH: begin
                    ctl.en = 1'b1;
                    if (match) begin
                        n_phase = jsfe_pkg::PH_COLON;
                    end
                end
                jsfe_pkg::PH_COLON: begin
                    if (i_byte_value == jsfe_pkg::COLON) begin
                        n_phase = jsfe_pkg::PH_SPACE;
                    end
                end
                jsfe_pkg::PH_SPACE: begin
                    if (!is_ws) begin
                        if (i_byte_value == jsfe_pkg::QUOTE && r_cap != '0) begin
                            n_phase = jsfe_pkg::PH_VALUE;
                            n_raw   = '0;
                            n_pend  = 1'b0;
                        end else begin
                            items[nemit] = '{value_byte: '0, is_status: 1'b1, found: 1'b0};
                            nemit        = nemit + jsfe_pkg::PUSH_W'(1);
                            n_phase      = jsfe_pkg::PH_DONE;
                        end
                    end
                end
                jsfe_pkg::PH_VALUE: begin
                    if (r_pend) begin
                        n_pend = 1'b0;
                        if (i_byte_value == jsfe_pkg::QUOTE) begin
                            // escaped quote, possibly cut after its backslash
                            if (r_raw < limit) begin
                                items[nemit] = '{value_byte: jsfe_pkg::QUOTE,
                                                 is_status: 1'b0, found: 1'b0};
                                nemit        = nemit + jsfe_pkg::PUSH_W'(1);
                            end else if (r_raw <= limit) begin
                                items[nemit] = '{value_byte: jsfe_pkg::BSLASH,
                                                 is_status: 1'b0, found: 1'b0};
                                nemit        = nemit + jsfe_pkg::PUSH_W'(1);
                            end
                            if (r_raw < limit) begin
                                n_raw = r_raw + jsfe_pkg::RAW_W'(1);
                            end
                            cont = 1'b0;
                        end else if (r_raw <= limit) begin
                            items[nemit] = '{value_byte: jsfe_pkg::BSLASH,
                                             is_status: 1'b0, found: 1'b0};
                            nemit        = nemit + jsfe_pkg::PUSH_W'(1);
                        end
                    end
                    if (cont) begin
                        if (i_byte_value == jsfe_pkg::QUOTE) begin
                            items[nemit] = '{value_byte: '0, is_status: 1'b1,
                                             found: (r_cap != '0)};
                            nemit        = nemit + jsfe_pkg::PUSH_W'(1);
                            n_phase      = jsfe_pkg::PH_DONE;
                        end else if (i_byte_value == jsfe_pkg::BSLASH) begin
                            n_pend = 1'b1;
                            if (r_raw <= limit) begin
                                n_raw = r_raw + jsfe_pkg::RAW_W'(1);
                            end
                        end else if (r_raw < limit) begin
                            items[nemit] = '{value_byte: i_byte_value,
                                             is_status: 1'b0, found: 1'b0};
                            nemit        = nemit + jsfe_pkg::PUSH_W'(1);
                            n_raw        = r_raw + jsfe_pkg::RAW_W'(1);
                        end
                    end
                end
                jsfe_pkg::PH_DONE: begin
                end
                default: begin
                end
            endcase
            if (i_end_of_text) begin
                if (n_phase != jsfe_pkg::PH_DONE) begin
                    items[nemit] = '{value_byte: '0, is_status: 1'b1, found: 1'b0};
                    nemit        = nemit + jsfe_pkg::PUSH_W'(1);
                end
                ctl.clr = 1'b1;
                n_phase = jsfe_pkg::PH_SEARCH;
                n_raw   = '0;
                n_pend  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsfe_pkg::PH_SEARCH;
            r_raw   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_raw   <= n_raw;
            r_pend  <= n_pend;
        end
    end

    // configuration registers and sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= '0;
            r_cap     <= jsfe_pkg::CAP_RESET;
            r_sw_busy <= 1'b0;
            r_sw_cnt  <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= r_sw_busy;
            if (r_sw_busy) begin
                r_sw_cnt <= r_sw_cnt + jsfe_pkg::KEY_AW'(1);
                if (r_sw_cnt == jsfe_pkg::KEY_AW'(r_key_len - jsfe_pkg::KL_W'(1))) begin
                    r_sw_busy <= 1'b0;
                end
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    jsfe_pkg::CFG_KEY_LENGTH: begin
                        r_key_len <= cfg_kl;
                        r_sw_busy <= (cfg_kl != '0);
                        r_sw_cnt  <= '0;
                    end
                    jsfe_pkg::CFG_VALUE_CAPACITY: begin
                        r_cap <= cfg_cap;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_sw_cnt;
    end

    // result queue
    jsfe_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (nemit),
        .i_push   (items),
        .i_pop    (!i_stall),
        .o_room   (room),
        .o_valid  (o_valid),
        .o_head   (head)
    );

    assign o_value_byte = head.value_byte;
    assign o_is_status  = head.is_status;
    assign o_found      = head.found;

    a_sweep_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sw_busy || r_rd_vld) |-> o_stall)
        else $error("request taken during key sweep");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_status) |-> (o_value_byte == '0))
        else $error("status result carries a value byte");

    a_eot_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (text_acc && i_end_of_text) |=> (r_phase == jsfe_pkg::PH_SEARCH && !r_pend
                                         && r_raw == '0))
        else $error("end of text did not restart the search");

    a_pend_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_phase == jsfe_pkg::PH_VALUE))
        else $error("pending backslash outside a value");

endmodule

[tb/tb_json_string_field_extractor.sv]
// ----------------------------------------------------------------------------
// tb_json_string_field_extractor
// self-checking bench: streams keys and json text through the extractor,
// predicts every value byte and status item, and compares them in order
// ----------------------------------------------------------------------------
typedef logic [jsfe_pkg::BYTE_W-1:0] t_text_q [$];

class value_scoreboard;
    logic [jsfe_pkg::BYTE_W-1:0] key_bytes [jsfe_pkg::KEY_MAX];
    logic [jsfe_pkg::BYTE_W-1:0] window [jsfe_pkg::WIN];
    int                          fill;
    logic [jsfe_pkg::PH_W-1:0]   phase;
    int                          raw_count;
    bit                          pending_bs;
    int                          key_len;
    int                          capacity;
    jsfe_pkg::t_item             due_values [$];
    int                          errors;

    function new();
        foreach (key_bytes[i]) key_bytes[i] = '0;
        key_len  = 0;
        capacity = int'(jsfe_pkg::CAP_RESET);
        errors   = 0;
        clear_text();
    endfunction

    function void clear_text();
        foreach (window[i]) window[i] = '0;
        fill       = 0;
        phase      = jsfe_pkg::PH_SEARCH;
        raw_count  = 0;
        pending_bs = 1'b0;
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endfunction

    function int pending();
        return due_values.size();
    endfunction

    function void due(logic [jsfe_pkg::BYTE_W-1:0] b, logic st, logic f);
        jsfe_pkg::t_item it;
        it.value_byte = b;
        it.is_status  = st;
        it.found      = f;
        due_values.push_back(it);
    endfunction

    function void write_register(logic [jsfe_pkg::CFG_AW-1:0] index,
                                 logic [jsfe_pkg::CFG_DW-1:0] data);
        if (index == jsfe_pkg::CFG_KEY_LENGTH) begin
            key_len = (int'(data[jsfe_pkg::KL_W-1:0]) > jsfe_pkg::KEY_MAX)
                      ? jsfe_pkg::KEY_MAX : int'(data[jsfe_pkg::KL_W-1:0]);
        end else begin
            capacity = (int'(data) > jsfe_pkg::VALUE_MAX) ? jsfe_pkg::VALUE_MAX : int'(data);
        end
    endfunction

    function void accept_request(logic cmd, logic [jsfe_pkg::BYTE_W-1:0] b,
                                 logic [jsfe_pkg::KL_W-1:0] idx, logic eot);
        int limit;
        int p;
        int base;
        int r;
        bit hit;
        bit handled;
        limit = (capacity == 0) ? 0 : capacity - 1;
        if (cmd == jsfe_pkg::CMD_KEY) begin
            if (int'(idx) < jsfe_pkg::KEY_MAX) key_bytes[idx] = b;
            return;
        end
        case (phase)
            jsfe_pkg::PH_SEARCH: begin
                for (int i = 0; i < jsfe_pkg::WIN - 1; i++) window[i] = window[i+1];
                window[jsfe_pkg::WIN-1] = b;
                if (fill < jsfe_pkg::WIN) fill++;
                p = key_len + 2;
                hit = (fill >= p);
                base = jsfe_pkg::WIN - p;
                for (int i = 0; i < p && hit; i++) begin
                    if (i == 0 || i == p - 1) begin
                        if (window[base+i] != jsfe_pkg::QUOTE) hit = 1'b0;
                    end else if (window[base+i] != key_bytes[i-1]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) phase = jsfe_pkg::PH_COLON;
            end
            jsfe_pkg::PH_COLON: begin
                if (b == jsfe_pkg::COLON) phase = jsfe_pkg::PH_SPACE;
            end
            jsfe_pkg::PH_SPACE: begin
                if (!(b == jsfe_pkg::SPACE || (b >= jsfe_pkg::TAB && b <= jsfe_pkg::CR))) begin
                    if (b == jsfe_pkg::QUOTE && capacity != 0) begin
                        phase      = jsfe_pkg::PH_VALUE;
                        raw_count  = 0;
                        pending_bs = 1'b0;
                    end else begin
                        due('0, 1'b1, 1'b0);
                        phase = jsfe_pkg::PH_DONE;
                    end
                end
            end
            jsfe_pkg::PH_VALUE: begin
                handled = 1'b0;
                if (pending_bs) begin
                    // raw position of the backslash that is waiting
                    r = raw_count - 1;
                    pending_bs = 1'b0;
                    if (b == jsfe_pkg::QUOTE) begin
                        if (r + 1 < limit) due(jsfe_pkg::QUOTE, 1'b0, 1'b0);
                        else if (r < limit) due(jsfe_pkg::BSLASH, 1'b0, 1'b0);
                        if (raw_count < limit) raw_count++;
                        handled = 1'b1;
                    end else if (r < limit) begin
                        due(jsfe_pkg::BSLASH, 1'b0, 1'b0);
                    end
                end
                if (!handled) begin
                    if (b == jsfe_pkg::QUOTE) begin
                        due('0, 1'b1, capacity != 0);
                        phase = jsfe_pkg::PH_DONE;
                    end else if (b == jsfe_pkg::BSLASH) begin
                        pending_bs = 1'b1;
                        if (raw_count <= limit) raw_count++;
                    end else begin
                        if (raw_count < limit) due(b, 1'b0, 1'b0);
                        if (raw_count < limit) raw_count++;
                    end
                end
            end
            default: ;
        endcase
        if (eot) begin
            if (phase != jsfe_pkg::PH_DONE) due('0, 1'b1, 1'b0);
            clear_text();
        end
    endfunction

    function void check_result(jsfe_pkg::t_item got);
        jsfe_pkg::t_item want;
        if (due_values.size() == 0) begin
            flag($sformatf("unexpected result: byte %02h status %0b found %0b",
                           got.value_byte, got.is_status, got.found));
        end else begin
            want = due_values.pop_front();
            if (got.value_byte !== want.value_byte || got.is_status !== want.is_status ||
                got.found !== want.found) begin
                flag($sformatf({"result mismatch: expected byte %02h status %0b found %0b,",
                                " got byte %02h status %0b found %0b"},
                               want.value_byte, want.is_status, want.found,
                               got.value_byte, got.is_status, got.found));
            end
        end
    endfunction
endclass

module tb_json_string_field_extractor;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 60;
    localparam int TEXT_PER_PHASE = 10;
    localparam int N_PHASES       = 8;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_valid       = 1'b0;
    logic                          o_stall;
    logic                          i_command     = jsfe_pkg::CMD_KEY;
    logic [jsfe_pkg::BYTE_W-1:0]   i_byte_value  = 8'h01;
    logic [jsfe_pkg::KL_W-1:0]     i_key_index   = '0;
    logic                          i_end_of_text = 1'b0;
    logic                          o_valid;
    logic                          i_stall       = 1'b0;
    logic [jsfe_pkg::BYTE_W-1:0]   o_value_byte;
    logic                          o_is_status;
    logic                          o_found;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [jsfe_pkg::CFG_AW-1:0]   i_cfg_index   = jsfe_pkg::CFG_KEY_LENGTH;
    logic [jsfe_pkg::CFG_DW-1:0]   i_cfg_data    = '0;

    value_scoreboard               sb;
    logic [jsfe_pkg::BYTE_W-1:0]   key_text [jsfe_pkg::KEY_MAX];
    jsfe_pkg::t_item               seen_item;
    bit                            quiet       = 1'b0;
    int                            hold_orders = 0;
    int                            hold_served = 0;
    int                            hold_left   = 0;
    int                            cycle_count = 0;

    json_string_field_extractor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_byte_value  (i_byte_value),
        .i_key_index   (i_key_index),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value_byte  (o_value_byte),
        .o_is_status   (o_is_status),
        .o_found       (o_found),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_item.value_byte = o_value_byte;
            seen_item.is_status  = o_is_status;
            seen_item.found      = o_found;
            sb.check_result(seen_item);
        end
        if (hold_served != hold_orders) begin
            hold_served = hold_orders;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 8);
        end
    end

    task automatic send_request(logic cmd, logic [jsfe_pkg::BYTE_W-1:0] b,
                                logic [jsfe_pkg::KL_W-1:0] idx, logic eot);
        if (!quiet && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_byte_value  <= b;
        i_key_index   <= idx;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_stall);
        sb.accept_request(cmd, b, idx, eot);
    endtask

    task automatic send_key(int idx, logic [jsfe_pkg::BYTE_W-1:0] b);
        send_request(jsfe_pkg::CMD_KEY, b, jsfe_pkg::KL_W'(idx), 1'($urandom_range(1)));
        if (idx < jsfe_pkg::KEY_MAX) key_text[idx] = b;
    endtask

    task automatic send_text(t_text_q q, bit stray_keys);
        for (int i = 0; i < q.size(); i++) begin
            if (stray_keys && $urandom_range(99) < 3)
                send_key($urandom_range(127), 8'($urandom_range(1, 255)));
            send_request(jsfe_pkg::CMD_TEXT, q[i], jsfe_pkg::KL_W'($urandom_range(127)),
                         i == q.size() - 1);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(int key_len, int capacity);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= jsfe_pkg::CFG_KEY_LENGTH;
        i_cfg_data  <= jsfe_pkg::CFG_DW'(key_len);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(jsfe_pkg::CFG_KEY_LENGTH, jsfe_pkg::CFG_DW'(key_len));
        i_cfg_index <= jsfe_pkg::CFG_VALUE_CAPACITY;
        i_cfg_data  <= jsfe_pkg::CFG_DW'(capacity);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(jsfe_pkg::CFG_VALUE_CAPACITY, jsfe_pkg::CFG_DW'(capacity));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_text_q from_string(string s);
        t_text_q q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [jsfe_pkg::BYTE_W-1:0] blank_byte();
        int r;
        r = $urandom_range(5);
        return (r == 0) ? jsfe_pkg::SPACE : jsfe_pkg::TAB + 8'(r - 1);
    endfunction

    function automatic t_text_q make_document(int key_len, bit broken);
        t_text_q q;
        int n;
        int sel;
        logic [jsfe_pkg::BYTE_W-1:0] c;
        // decoy member ahead of the wanted key
        if ($urandom_range(3) == 0) begin
            q.push_back(jsfe_pkg::QUOTE);
            q.push_back(8'h7A);
            q.push_back(jsfe_pkg::QUOTE);
            q.push_back(jsfe_pkg::COLON);
            q.push_back(8'h31);
            q.push_back(8'h2C);
        end
        q.push_back(jsfe_pkg::QUOTE);
        for (int i = 0; i < key_len; i++) q.push_back(key_text[i]);
        q.push_back(jsfe_pkg::QUOTE);
        repeat ($urandom_range(2)) q.push_back(blank_byte());
        if ($urandom_range(9) == 0) q.push_back(8'h78);
        q.push_back(jsfe_pkg::COLON);
        repeat ($urandom_range(2)) q.push_back(blank_byte());
        if (broken && $urandom_range(2) == 0) begin
            q.push_back(8'($urandom_range(1, 255)));
        end else begin
            q.push_back(jsfe_pkg::QUOTE);
            n = $urandom_range(10);
            for (int i = 0; i < n; i++) begin
                sel = $urandom_range(9);
                if (sel < 2) begin
                    q.push_back(jsfe_pkg::BSLASH);
                    q.push_back(jsfe_pkg::QUOTE);
                end else if (sel == 2) begin
                    q.push_back(jsfe_pkg::BSLASH);
                end else if (sel == 3) begin
                    q.push_back(8'($urandom_range(128, 255)));
                end else begin
                    c = 8'($urandom_range(32, 126));
                    if (c == jsfe_pkg::QUOTE || c == jsfe_pkg::BSLASH) c = 8'h61;
                    q.push_back(c);
                end
            end
            // unterminated value, sometimes with a dangling backslash
            if (broken && $urandom_range(1)) begin
                if ($urandom_range(1)) q.push_back(jsfe_pkg::BSLASH);
            end else begin
                q.push_back(jsfe_pkg::QUOTE);
            end
        end
        repeat ($urandom_range(2)) q.push_back(8'($urandom_range(1, 255)));
        return q;
    endfunction

    function automatic t_text_q make_noise();
        t_text_q q;
        repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(1, 255)));
        return q;
    endfunction

    initial begin
        int phase_kl  [N_PHASES] = '{3, 1, 5, 2, 9, 0, 4, 6};
        int phase_cap [N_PHASES] = '{511, 0, 2, 1, 3, 256, 8, 300};
        int kl_eff;
        int sent;
        int drain;
        t_text_q doc;

        sb = new();
        foreach (key_text[i]) key_text[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        send_key(0, 8'h61);
        send_key(1, 8'h62);
        send_key(127, 8'hFF);
        wait_idle();
        write_settings(2, 256);
        send_text(from_string("\"ab\" :\t\"\\\"z\\x\"}"), 1'b0);
        send_text(from_string("\"ab\":5"), 1'b0);
        send_text(from_string("\"a\""), 1'b0);
        // receiver holds off while a long value fills the queue
        hold_orders++;
        send_text(from_string("\"ab\":\"0123456789abcdefghij\""), 1'b0);
        wait_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            kl_eff = (phase_kl[p] > jsfe_pkg::KEY_MAX) ? jsfe_pkg::KEY_MAX : phase_kl[p];
            for (int i = 0; i < kl_eff; i++) send_key(i, 8'($urandom_range(1, 255)));
            send_key($urandom_range(jsfe_pkg::KEY_MAX, 127), 8'($urandom_range(1, 255)));
            wait_idle();
            write_settings(phase_kl[p], phase_cap[p]);
            quiet = (p == 5);
            if (p == 6) hold_orders++;
            sent = 0;
            while (sent < TEXT_PER_PHASE) begin
                if ($urandom_range(4) == 0)
                    doc = make_noise();
                else
                    doc = make_document(kl_eff, $urandom_range(4) == 0);
                send_text(doc, 1'b1);
                if (p == 2 && sent == 0) wait_idle();
                sent += doc.size();
            end
            wait_idle();
            quiet = 1'b0;
        end

        i_valid <= 1'b0;
        drain = 0;
        while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived", sb.pending());
            sb.errors += sb.pending();
        end
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
